### rtl/ivs_pkg.sv
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared constants, codes and types of the iterative vector smoothing block.
// ----------------------------------------------------------------------------
`default_nettype none

package ivs_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int POS_W          = 3;
    localparam int PASS_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int VECTOR_LEN_DEF = 8;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 16'd655;
    localparam logic [PASS_W-1:0]   MAX_PASSES_RST = 16'd4096;
    localparam logic [15:0]         RECIP3         = 16'd21845;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PASSES = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SMOOTH,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_INNER,
        KIND_LEFT,
        KIND_RIGHT
    } cell_kind_t;

    typedef struct packed {
        logic shift;
        logic smooth;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/ivs_cell.sv
// ----------------------------------------------------------------------------
// ivs_cell
// One element of the smoothing chain: holds a sample, shifts it toward the
// output end, replaces it with the local mean, and flags closeness to the head.
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_cell (
    input  wire logic                          clk,
    input  wire ivs_pkg::cell_ctl_t            ctl,
    input  wire ivs_pkg::cell_kind_t           kind,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]  left_val,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]  right_val,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]  head_val,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]  threshold,
    output logic      [ivs_pkg::SAMPLE_W-1:0]  val,
    output logic                               close
);

    logic [ivs_pkg::SAMPLE_W-1:0] val_reg;
    logic [ivs_pkg::SAMPLE_W-1:0] val_next;
    logic [ivs_pkg::SAMPLE_W+1:0] sum3;
    logic [31:0]                  prod;
    logic [ivs_pkg::SAMPLE_W:0]   sum_left;
    logic [ivs_pkg::SAMPLE_W:0]   sum_right;
    logic [ivs_pkg::SAMPLE_W-1:0] avg;
    logic [ivs_pkg::SAMPLE_W-1:0] diff;

    always_comb
    begin
        sum3      = 18'(left_val) + 18'(val_reg) + 18'(right_val);
        prod      = 32'(sum3) * 32'(ivs_pkg::RECIP3);
        sum_left  = 17'(val_reg) + 17'(right_val);
        sum_right = 17'(left_val) + 17'(val_reg);
        case (kind)
            ivs_pkg::KIND_LEFT:  avg = sum_left[ivs_pkg::SAMPLE_W:1];
            ivs_pkg::KIND_RIGHT: avg = sum_right[ivs_pkg::SAMPLE_W:1];
            default:             avg = prod[31:16];
        endcase
    end

    always_comb
    begin
        if (ctl.shift)
        begin
            val_next = right_val;
        end
        else if (ctl.smooth)
        begin
            val_next = avg;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_comb
    begin
        diff  = (val_reg >= head_val) ? (val_reg - head_val) : (head_val - val_reg);
        close = (diff < threshold);
    end

    assign val = val_reg;

endmodule

`default_nettype wire

### rtl/ivs_ctrl.sv
// ----------------------------------------------------------------------------
// ivs_ctrl
// Sequencer of the smoothing chain: load, smooth and check passes, emit;
// holds the configuration registers and the pass and position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_ctrl #(
    parameter int VECTOR_LEN = ivs_pkg::VECTOR_LEN_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            all_close,
    output ivs_pkg::cell_ctl_t                   ctl,
    output logic      [ivs_pkg::SAMPLE_W-1:0]    threshold,
    output logic      [ivs_pkg::POS_W-1:0]       position,
    output logic                                 final_res,
    output logic                                 converged,
    output logic      [ivs_pkg::PASS_W-1:0]      passes_used
);

    localparam int IDX_W = $clog2(VECTOR_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VECTOR_LEN - 1);

    ivs_pkg::state_t state_reg;
    ivs_pkg::state_t state_next;

    logic [ivs_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [ivs_pkg::PASS_W-1:0]   max_passes_reg;
    logic [IDX_W-1:0]             cnt_reg;
    logic [IDX_W-1:0]             cnt_next;
    logic [ivs_pkg::POS_W-1:0]    pos_reg;
    logic [ivs_pkg::POS_W-1:0]    pos_next;
    logic [ivs_pkg::PASS_W-1:0]   pass_reg;
    logic [ivs_pkg::PASS_W-1:0]   pass_next;
    logic                         conv_reg;
    logic                         conv_next;
    logic [ivs_pkg::PASS_W-1:0]   cap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= ivs_pkg::THRESHOLD_RST;
            max_passes_reg <= ivs_pkg::MAX_PASSES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ivs_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data;
                ivs_pkg::REG_MAX_PASSES: max_passes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cap = (max_passes_reg == '0) ? ivs_pkg::PASS_W'(1) : max_passes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ivs_pkg::ST_LOAD;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            pass_reg  <= '0;
            conv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            pass_reg  <= pass_next;
            conv_reg  <= conv_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        pass_next  = pass_reg;
        conv_next  = conv_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ivs_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.shift = 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        pass_next  = '0;
                        state_next = ivs_pkg::ST_SMOOTH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            ivs_pkg::ST_SMOOTH:
            begin
                ctl.smooth = 1'b1;
                pass_next  = pass_reg + ivs_pkg::PASS_W'(1);
                state_next = ivs_pkg::ST_CHECK;
            end
            ivs_pkg::ST_CHECK:
            begin
                if (all_close || (pass_reg >= cap))
                begin
                    conv_next  = all_close;
                    cnt_next   = '0;
                    pos_next   = '0;
                    state_next = ivs_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = ivs_pkg::ST_SMOOTH;
                end
            end
            ivs_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    ctl.shift = 1'b1;
                    pos_next  = pos_reg + ivs_pkg::POS_W'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = ivs_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ivs_pkg::ST_LOAD;
            end
        endcase
    end

    assign threshold   = threshold_reg;
    assign position    = pos_reg;
    assign final_res   = (state_reg == ivs_pkg::ST_EMIT) && (cnt_reg == LAST_IDX);
    assign converged   = conv_reg;
    assign passes_used = pass_reg;

endmodule

`default_nettype wire

### rtl/iterative_vector_smoothing.sv
// ----------------------------------------------------------------------------
// iterative_vector_smoothing
// Iterative three-point averaging (two-point at both ends) of a short vector of
// Q0.16 samples, held in a chain of cells that shift during load and emission
// and average in place.
// Usage:
//   Input channel (in_valid / in_stall / sample) takes one sample per cycle
//   while loading; in_stall is high from the last sample until the whole
//   smoothed vector has been delivered.
//   Each smoothing pass averages every cell at once in ST_SMOOTH, then
//   checks all cells against the head element and the pass cap in ST_CHECK.
//   Output channel (out_valid / out_stall / value ...) then shows the vector
//   one element per cycle while out_stall is low, position 0 first;
//   final_res marks the last one. While out_stall is high the shown
//   element and its fields hold.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; unknown indexes are dropped.
//   Reset clears the sequencer to loading and restores the default threshold
//   and pass cap; stored samples are reloaded by the next vector.
// ----------------------------------------------------------------------------
`default_nettype none

module iterative_vector_smoothing #(
    parameter int VECTOR_LEN = ivs_pkg::VECTOR_LEN_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]    sample,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [ivs_pkg::SAMPLE_W-1:0]    value,
    output logic      [ivs_pkg::POS_W-1:0]       position,
    output logic                                 final_res,
    output logic                                 converged,
    output logic      [ivs_pkg::PASS_W-1:0]      passes_used,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ivs_pkg::cell_ctl_t           ctl;
    logic [ivs_pkg::SAMPLE_W-1:0] threshold;
    logic [ivs_pkg::SAMPLE_W-1:0] cell_val [VECTOR_LEN];
    logic [VECTOR_LEN-1:0]        close_vec;
    logic                         all_close;

    assign all_close = &close_vec;
    assign value     = cell_val[0];

    ivs_ctrl #(
        .VECTOR_LEN (VECTOR_LEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .all_close   (all_close),
        .ctl         (ctl),
        .threshold   (threshold),
        .position    (position),
        .final_res   (final_res),
        .converged   (converged),
        .passes_used (passes_used)
    );

    for (genvar i = 0; i < VECTOR_LEN; i++)
    begin : g_cell
        logic [ivs_pkg::SAMPLE_W-1:0] left_val;
        logic [ivs_pkg::SAMPLE_W-1:0] right_val;
        ivs_pkg::cell_kind_t          kind;

        if (i == 0)
        begin : g_head
            assign left_val  = cell_val[0];
            assign right_val = cell_val[i+1];
            assign kind      = ivs_pkg::KIND_LEFT;
        end
        else if (i == VECTOR_LEN - 1)
        begin : g_tail
            assign left_val  = cell_val[i-1];
            assign right_val = sample;
            assign kind      = ivs_pkg::KIND_RIGHT;
        end
        else
        begin : g_mid
            assign left_val  = cell_val[i-1];
            assign right_val = cell_val[i+1];
            assign kind      = ivs_pkg::KIND_INNER;
        end

        ivs_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .kind      (kind),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .threshold (threshold),
            .val       (cell_val[i]),
            .close     (close_vec[i])
        );
    end

endmodule

`default_nettype wire

### rtl/ivs_checker.sv
// ----------------------------------------------------------------------------
// ivs_checker
// Port-level checks of the smoothing block: input closed during emission,
// element order, vector end, nonzero passes and stalled output stability.
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [ivs_pkg::SAMPLE_W-1:0]    sample,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [ivs_pkg::SAMPLE_W-1:0]    value,
    input wire logic [ivs_pkg::POS_W-1:0]       position,
    input wire logic                            final_res,
    input wire logic                            converged,
    input wire logic [ivs_pkg::PASS_W-1:0]      passes_used,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic unused_ok;
    assign unused_ok = &{in_valid, sample, converged, cfg_valid, cfg_ready, cfg_index, cfg_data};

    a_no_input_while_emitting: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall
    ) else $error("input open while a vector is emitted");

    a_position_advances: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !final_res)
            |=> (out_valid && position == $past(position) + 3'd1
                 && passes_used == $past(passes_used))
    ) else $error("element order broken inside a vector");

    a_vector_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && final_res) |=> (!out_valid && !in_stall)
    ) else $error("emission did not end after the last element");

    a_passes_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (passes_used != '0)
    ) else $error("vector emitted without a smoothing pass");

    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(position))
    ) else $error("stalled output changed");

endmodule

bind iterative_vector_smoothing ivs_checker u_ivs_checker (.*);

`default_nettype wire

### tb/ivs_smoothing_checker.sv
// ----------------------------------------------------------------------------
// ivs_smoothing_checker
// Watches the sample, result and register channels of the smoothing block,
// runs its own copy of the load / average / convergence sequence on every
// completed vector and compares each emitted element field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_smoothing_checker #(
    parameter int VECTOR_LEN = ivs_pkg::VECTOR_LEN_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [ivs_pkg::SAMPLE_W-1:0]    value,
    input  wire logic [ivs_pkg::POS_W-1:0]       position,
    input  wire logic                            final_res,
    input  wire logic                            converged,
    input  wire logic [ivs_pkg::PASS_W-1:0]      passes_used,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   outstanding
);

    import ivs_pkg::*;

    typedef logic [VECTOR_LEN-1:0][SAMPLE_W-1:0] vec_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]    position;
        logic                final_res;
        logic                converged;
        logic [PASS_W-1:0]   passes;
    } smoothed_elem_t;

    vec_t                held;
    int                  loaded;
    logic [SAMPLE_W-1:0] tolerance;
    logic [PASS_W-1:0]   pass_cap;
    smoothed_elem_t      smoothed_due [$];
    smoothed_elem_t      want;
    logic                bad;

    function automatic vec_t average_pass(input vec_t src);
        vec_t        dst;
        logic [16:0] pair;
        logic [47:0] sum;
        logic [47:0] prod;
        int          i;
        pair = {1'b0, src[0]} + {1'b0, src[1]};
        dst[0] = pair[16:1];
        for (i = 1; i + 1 < VECTOR_LEN; i++)
        begin
            sum = {32'd0, src[i-1]} + {32'd0, src[i]} + {32'd0, src[i+1]};
            prod = sum * RECIP3;
            dst[i] = prod[31:16];
        end
        pair = {1'b0, src[VECTOR_LEN-2]} + {1'b0, src[VECTOR_LEN-1]};
        dst[VECTOR_LEN-1] = pair[16:1];
        return dst;
    endfunction

    function automatic logic settled(input vec_t v, input logic [SAMPLE_W-1:0] tol);
        logic [16:0] d;
        int          i;
        for (i = 0; i < VECTOR_LEN; i++)
        begin
            d = (v[i] >= v[0]) ? {1'b0, v[i]} - {1'b0, v[0]} : {1'b0, v[0]} - {1'b0, v[i]};
            if (d >= {1'b0, tol})
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_vector();
        logic [PASS_W-1:0] limit;
        logic [PASS_W-1:0] runs;
        logic              ok;
        smoothed_elem_t    e;
        int                i;
        limit = (pass_cap == '0) ? PASS_W'(1) : pass_cap;
        runs = '0;
        ok = 1'b0;
        while (!ok && runs < limit)
        begin
            held = average_pass(held);
            runs++;
            ok = settled(held, tolerance);
        end
        for (i = 0; i < VECTOR_LEN; i++)
        begin
            e.value = held[i];
            e.position = POS_W'(i);
            e.final_res = (i == VECTOR_LEN - 1);
            e.converged = ok;
            e.passes = runs;
            smoothed_due.push_back(e);
        end
    endtask

    function automatic logic differs(input string what, input logic [2:0] pos,
                                     input logic [15:0] exp_v, input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch at element %0d: expected %0h, actual %0h",
                     $time, what, pos, exp_v, got_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance = THRESHOLD_RST;
            pass_cap = MAX_PASSES_RST;
            loaded = 0;
            held = '0;
            smoothed_due.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THRESHOLD)
                    tolerance = cfg_data;
                else if (cfg_index == REG_MAX_PASSES)
                    pass_cap = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                held[loaded] = sample;
                loaded++;
                if (loaded == VECTOR_LEN)
                begin
                    predict_vector();
                    loaded = 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (smoothed_due.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual value %0h position %0d",
                             $time, value, position);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = smoothed_due.pop_front();
                    bad = differs("value", want.position, want.value, value);
                    bad |= differs("position", want.position, 16'(want.position),
                                   16'(position));
                    bad |= differs("final_res", want.position, 16'(want.final_res),
                                   16'(final_res));
                    bad |= differs("converged", want.position, 16'(want.converged),
                                   16'(converged));
                    bad |= differs("passes_used", want.position, want.passes, passes_used);
                    if (bad)
                        fail_count <= fail_count + 1;
                end
            end
            outstanding <= smoothed_due.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_iterative_vector_smoothing.sv
// ----------------------------------------------------------------------------
// tb_iterative_vector_smoothing
// Drives whole vectors of samples into the smoothing block in random bursts,
// stalls the result side on a changing pattern and retunes tolerance and pass
// cap between vectors; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_iterative_vector_smoothing;

    import ivs_pkg::*;

    localparam int VLEN        = VECTOR_LEN_DEF;
    localparam int ITEM_TARGET = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_FLAT,
        SHAPE_RAIL,
        SHAPE_RAMP
    } shape_t;

    typedef logic [VLEN-1:0][SAMPLE_W-1:0] vec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   value;
    logic [POS_W-1:0]      position;
    logic                  final_res;
    logic                  converged;
    logic [PASS_W-1:0]     passes_used;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    outstanding;

    int burst_left = 0;
    int sent = 0;
    int phase = 0;
    int mode = 0;
    int mode_left = 0;
    int run_left = 0;
    logic run_on = 1'b0;
    vec_t v;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    iterative_vector_smoothing #(.VECTOR_LEN(VLEN)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall), .value(value),
        .position(position), .final_res(final_res), .converged(converged),
        .passes_used(passes_used),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ivs_smoothing_checker #(.VECTOR_LEN(VLEN)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall), .value(value),
        .position(position), .final_res(final_res), .converged(converged),
        .passes_used(passes_used),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // result-side stall: quiet, light, heavy and long-run modes picked at random
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
        end
        else
            mode_left--;
        case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 20);
                    run_on = !run_on;
                end
                run_left--;
                out_stall <= run_on;
            end
        endcase
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic send_vector(input vec_t vec);
        for (int i = 0; i < VLEN; i++)
            send_sample(vec[i]);
    endtask

    // hold until every element is out, then let the sequencer return to load
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    function automatic vec_t random_vector(input shape_t shape);
        vec_t        r;
        logic [31:0] base;
        logic [31:0] step;
        logic [31:0] t;
        base = $urandom_range(0, 65535);
        step = $urandom_range(0, 9000);
        for (int k = 0; k < VLEN; k++)
        begin
            case (shape)
                SHAPE_NOISE: r[k] = SAMPLE_W'($urandom_range(0, 65535));
                SHAPE_FLAT:
                begin
                    t = base + $urandom_range(0, 1500);
                    r[k] = (t > 65535) ? 16'hFFFF : t[15:0];
                end
                SHAPE_RAIL: r[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:
                begin
                    t = base + k * step;
                    r[k] = (t > 65535) ? 16'hFFFF : t[15:0];
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tolerance();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_cap();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return CFG_DATA_W'($urandom_range(257, 4096));
            default: return CFG_DATA_W'($urandom_range(2, 256));
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: alternating rails, then a flat full-scale vector
        for (int i = 0; i < VLEN; i++)
            v[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
        send_vector(v);
        send_vector('1);
        drain();

        // zero tolerance and zero cap: one pass, never converged
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_MAX_PASSES, 16'h0000);
        cfg_valid <= 1'b0;
        v = '0;
        v[VLEN-1] = 16'hFFFF;
        send_vector(v);
        drain();

        // full pass cap with zero tolerance
        write_reg(REG_MAX_PASSES, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_vector(random_vector(SHAPE_NOISE));
        drain();

        while (sent < ITEM_TARGET)
        begin
            write_reg(REG_THRESHOLD, (phase == 0) ? 16'hFFFF : pick_tolerance());
            write_reg(REG_MAX_PASSES, pick_cap());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                send_vector(random_vector(shape_t'($urandom_range(0, 3))));
            drain();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("iterative_vector_smoothing verification clean");
        else
            $display("iterative_vector_smoothing verification failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("iterative_vector_smoothing verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/ivs_pkg.sv
rtl/ivs_cell.sv
rtl/ivs_ctrl.sv
rtl/iterative_vector_smoothing.sv
rtl/ivs_checker.sv
tb/ivs_smoothing_checker.sv
tb/tb_iterative_vector_smoothing.sv
